// ----- hdl/bop_pkg.sv -----
// ----------------------------------------------------------------------------
// Bisector offset point package
// Shared widths, constants and the arctangent table of the angle datapath.
// ----------------------------------------------------------------------------
package bop_pkg;

  localparam int DISTW      = 20;
  localparam int EW         = 26;
  localparam int AW         = 25;
  localparam int NXW        = DISTW + AW;
  localparam int RADW       = 64;
  localparam int SQ_STEPS   = 32;
  localparam int LSW        = 32;
  localparam int NUMW       = 54;
  localparam int DENW       = 33;
  localparam int QW         = 22;
  localparam int O2W        = 23;
  localparam int XW         = 54;
  localparam int ZW         = 25;
  localparam int ANGW       = 16;
  localparam int NORM_MSB   = 50;
  localparam int ATAN_N     = 24;

  localparam logic [DISTW-1:0] DIST_RESET = 20'd96993;
  localparam logic signed [ANGW-1:0] ANGLE_LIMIT = 16'sd23040;

  localparam logic [22:0] ATAN_TAB [ATAN_N] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
    23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833,
    23'd917, 23'd458, 23'd229, 23'd115, 23'd57, 23'd29,
    23'd14, 23'd7, 23'd4, 23'd2, 23'd1, 23'd0
  };

endpackage

// ----- hdl/bop_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; the quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module bop_div #(
  parameter int NW = 54,
  parameter int DW = 33,
  parameter int QW = 22
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  localparam int RW = DW + 1;

  logic [RW-1:0] rem_r [0:QW-1];
  logic [QW-1:0] low_r [0:QW-1];
  logic [DW-1:0] den_r [0:QW-1];
  logic [QW-1:0] quo_r [1:QW];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= RW'(num_i[NW-1:QW]);
      low_r[0] <= num_i[QW-1:0];
      den_r[0] <= den_i;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [RW-1:0] trial;
    logic          ge;
    logic [QW-1:0] qin;

    assign trial = {rem_r[i][DW-1:0], low_r[i][QW-1]};
    assign ge    = trial >= RW'(den_r[i]);

    if (i == 0) begin : g_first
      assign qin = '0;
    end else begin : g_rest
      assign qin = quo_r[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[i+1] <= {qin[QW-2:0], ge};
      end
    end

    if (i < QW - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i+1] <= ge ? (trial - RW'(den_r[i])) : trial;
          low_r[i+1] <= {low_r[i][QW-2:0], 1'b0};
          den_r[i+1] <= den_r[i];
        end
      end
    end
  end

  assign quo_o = quo_r[QW];

endmodule

// ----- hdl/bop_cordic.sv -----
// ----------------------------------------------------------------------------
// Pipelined clockwise angle unit
// Mirrors and normalizes a vector, runs CORDIC vectoring and folds the angle.
// ----------------------------------------------------------------------------
module bop_cordic import bop_pkg::*; #(
  parameter int IW    = 26,
  parameter int STEPS = 16
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [IW-1:0]   x_i,
  input  logic signed [IW-1:0]   y_i,
  output logic signed [ANGW-1:0] ang_o
);

  localparam int MW  = IW + 1;
  localparam int SHW = $clog2(XW);

  logic signed [MW-1:0]   xe;
  logic signed [MW-1:0]   ye;
  logic signed [MW-1:0]   xm;
  logic signed [MW-1:0]   ym;
  logic signed [MW-1:0]   aym;
  logic                   spec;
  logic signed [ANGW-1:0] sang;

  logic                   sp0_r;
  logic signed [ANGW-1:0] sa0_r;
  logic signed [MW-1:0]   xm0_r;
  logic signed [MW-1:0]   ym0_r;
  logic [MW-1:0]          m0_r;

  logic [SHW-1:0]         msb;
  logic                   sp1_r;
  logic signed [ANGW-1:0] sa1_r;
  logic signed [MW-1:0]   xm1_r;
  logic signed [MW-1:0]   ym1_r;
  logic [SHW-1:0]         sh1_r;

  logic signed [XW-1:0]   cx_r [0:STEPS-1];
  logic signed [XW-1:0]   cy_r [0:STEPS-1];
  logic signed [ZW-1:0]   cz_r [1:STEPS];
  logic                   sp_r [0:STEPS];
  logic signed [ANGW-1:0] sa_r [0:STEPS];

  logic signed [ZW-1:0]   rneg;
  logic [ZW-1:0]          rabs;
  logic [ZW-1:0]          qmag;
  logic signed [ANGW-1:0] qclamp;
  logic signed [ANGW-1:0] ang_r;

  assign xe = MW'(x_i);
  assign ye = MW'(y_i);

  always_comb begin
    spec = 1'b0;
    sang = '0;
    if (x_i == '0) begin
      spec = 1'b1;
      if (y_i > 0) begin
        sang = -ANGLE_LIMIT;
      end else if (y_i < 0) begin
        sang = ANGLE_LIMIT;
      end
    end else if (y_i == '0) begin
      spec = 1'b1;
    end
    if (x_i < 0) begin
      xm = -xe;
      ym = -ye;
    end else begin
      xm = xe;
      ym = ye;
    end
    aym = (ym < 0) ? -ym : ym;
  end

  always_comb begin
    msb = '0;
    for (int i = 0; i < MW; i++) begin
      if (m0_r[i]) begin
        msb = SHW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp0_r <= spec;
      sa0_r <= sang;
      xm0_r <= xm;
      ym0_r <= ym;
      m0_r  <= (xm > aym) ? xm : aym;
      sp1_r <= sp0_r;
      sa1_r <= sa0_r;
      xm1_r <= xm0_r;
      ym1_r <= ym0_r;
      sh1_r <= SHW'(NORM_MSB) - msb;
      cx_r[0] <= XW'(xm1_r) <<< sh1_r;
      cy_r[0] <= XW'(ym1_r) <<< sh1_r;
      sp_r[0] <= sp1_r;
      sa_r[0] <= sa1_r;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    logic signed [ZW-1:0] zin;
    logic signed [ZW-1:0] at;

    assign at = $signed(ZW'(ATAN_TAB[i]));

    if (i == 0) begin : g_z0
      assign zin = '0;
    end else begin : g_zn
      assign zin = cz_r[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cz_r[i+1] <= (cy_r[i] > 0) ? (zin + at) : (zin - at);
        sp_r[i+1] <= sp_r[i];
        sa_r[i+1] <= sa_r[i];
      end
    end

    if (i < STEPS - 1) begin : g_fwd
      logic signed [XW-1:0] xs;
      logic signed [XW-1:0] ys;

      assign xs = cx_r[i] >>> i;
      assign ys = cy_r[i] >>> i;

      always_ff @(posedge clk) begin
        if (en) begin
          if (cy_r[i] > 0) begin
            cx_r[i+1] <= cx_r[i] + ys;
            cy_r[i+1] <= cy_r[i] - xs;
          end else begin
            cx_r[i+1] <= cx_r[i] - ys;
            cy_r[i+1] <= cy_r[i] + xs;
          end
        end
      end
    end
  end

  always_comb begin
    rneg = -cz_r[STEPS];
    rabs = (rneg < 0) ? ZW'(-rneg) : ZW'(rneg);
    qmag = (rabs + ZW'(128)) >> 8;
    if (qmag > ZW'(ANGLE_LIMIT)) begin
      qclamp = ANGLE_LIMIT;
    end else begin
      qclamp = ANGW'(qmag);
    end
    if (rneg < 0) begin
      qclamp = -qclamp;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r <= sp_r[STEPS] ? sa_r[STEPS] : qclamp;
    end
  end

  assign ang_o = ang_r;

endmodule

// ----- hdl/bisector_offset_point_and_angle.sv -----
// ----------------------------------------------------------------------------
// Bisector offset point and angles
// Picks the point at distance d on the perpendicular bisector of AB that is
// nearer the origin and gives its angle and the bisector angle.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  in_      slave      a_x, a_y, b_x, b_y
//  out_     master     target_x, target_y, target_angle, bisector_angle;
//                      coincident in tuser
//  cfg_     write      offset_distance
//
// One transfer is taken every cycle while the output is not stalled. Each
// item passes the 32 stage square root, the 23 stage dividers and the CORDIC.
// Reset clears the valid bits and loads the default offset distance.
// A stall on the output freezes the whole pipeline; nothing is lost.
// ----------------------------------------------------------------------------
module bisector_offset_point_and_angle import bop_pkg::*; #(
  parameter int COORD_WIDTH  = 24,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // a_x, a_y, b_x, b_y
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]     in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // target_x, target_y, target_angle, bisector_angle
  output logic [((2*COORD_WIDTH+2*ANGW+7)/8)*8-1:0] out_tdata,
  // coincident
  output logic                                   out_tuser,
  input  logic                                   cfg_we,
  input  logic [DISTW-1:0]                       cfg_wdata
);

  localparam int CW     = COORD_WIDTH;
  localparam int ST     = CORDIC_STEPS;
  localparam int SQ     = SQ_STEPS;
  localparam int DL     = QW + 1;
  localparam int HW     = ((CW + 1 > O2W) ? CW + 1 : O2W) + 1;
  localparam int PW     = CW + 1 + O2W;
  localparam int BW     = CW + 2;
  localparam int CL     = ST + 4;
  localparam int KMAX   = (CW > 24) ? CW - 24 : 0;
  localparam int OUT_DW = ((2*CW+2*ANGW+7)/8)*8;

  localparam logic signed [HW:0] CMAX = (HW+1)'((longint'(1) <<< (CW-1)) - longint'(1));
  localparam logic signed [HW:0] CMIN = -CMAX - (HW+1)'(1);

  typedef struct packed {
    logic        co;
    logic        eypos;
    logic        exneg;
    logic [CW:0] dx;
    logic [CW:0] dy;
    logic [CW:0] sx;
    logic [CW:0] sy;
  } side_t;

  typedef struct packed {
    logic          co;
    logic [CW-1:0] tx;
    logic [CW-1:0] ty;
  } tail_t;

  logic adv;
  logic [DISTW-1:0] d_r;

  logic signed [CW-1:0] ax, ay, bx, by;
  side_t s1_nxt;
  side_t s1_r;
  logic  v1_r, v2_r, v3_r;

  logic signed [63:0] wx, wy;
  logic signed [EW-1:0] ex_nxt, ey_nxt;
  side_t s2_nxt;
  side_t s2_r;
  logic signed [EW-1:0] s2_ex_r, s2_ey_r;

  side_t s3_r;
  logic [AW-1:0]   s3_aex_r, s3_aey_r;
  logic [2*AW-1:0] s3_sqx_r, s3_sqy_r;

  side_t side_r [0:SQ+DL];
  logic  vld_r  [0:SQ+DL];
  logic [NXW-1:0]  nx_r [0:SQ];
  logic [NXW-1:0]  ny_r [0:SQ];
  logic [RADW-1:0] sv_r [0:SQ-1];
  logic [RADW-1:0] sr_r [1:SQ];

  logic [LSW-1:0]  ls;
  logic [NUMW-1:0] num_x, num_y;
  logic [DENW-1:0] den;
  logic [QW-1:0]   qx, qy;

  side_t p1_r, p2_r;
  logic  pv1_r, pv2_r, pv3_r;
  logic signed [O2W-1:0] p1_o2x_r, p1_o2y_r, p2_o2x_r, p2_o2y_r;
  logic signed [PW-1:0]  p2_px_r, p2_py_r;
  logic signed [PW:0]    dot;
  logic signed [HW-1:0]  hx_nxt, hy_nxt;
  logic                  p3_co_r;
  logic signed [HW-1:0]  p3_hx_r, p3_hy_r;
  logic signed [BW-1:0]  p3_bx_r, p3_by_r;

  logic signed [HW:0]    hxp, hyp;
  tail_t                 tail_nxt;
  tail_t                 tail_r [1:CL];
  logic                  vt_r   [1:CL];
  logic signed [ANGW-1:0] tang, bang;

  assign adv       = !vt_r[CL] || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r <= DIST_RESET;
    end else if (cfg_we) begin
      d_r <= cfg_wdata;
    end
  end

  // Stage 1: differences and sums.
  assign ax = in_tdata[CW-1:0];
  assign ay = in_tdata[2*CW-1:CW];
  assign bx = in_tdata[3*CW-1:2*CW];
  assign by = in_tdata[4*CW-1:3*CW];

  always_comb begin
    s1_nxt       = '0;
    s1_nxt.co    = (ax == bx) && (ay == by);
    s1_nxt.dx    = (CW+1)'(bx) - (CW+1)'(ax);
    s1_nxt.dy    = (CW+1)'(by) - (CW+1)'(ay);
    s1_nxt.sx    = (CW+1)'(ax) + (CW+1)'(bx);
    s1_nxt.sy    = (CW+1)'(ay) + (CW+1)'(by);
  end

  // Stage 2: the difference vector is halved until it fits 25 bits.
  always_comb begin
    ex_nxt = '0;
    ey_nxt = '0;
    wx     = '0;
    wy     = '0;
    for (int k = KMAX; k >= 0; k--) begin
      wx = 64'($signed(s1_r.dx)) >>> k;
      wy = 64'($signed(s1_r.dy)) >>> k;
      if (wx < 64'sd33554432 && wx > -64'sd33554432 &&
          wy < 64'sd33554432 && wy > -64'sd33554432) begin
        ex_nxt = wx[EW-1:0];
        ey_nxt = wy[EW-1:0];
      end
    end
  end

  always_comb begin
    s2_nxt       = s1_r;
    s2_nxt.eypos = ey_nxt > 0;
    s2_nxt.exneg = ex_nxt < 0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      pv1_r <= 1'b0;
      pv2_r <= 1'b0;
      pv3_r <= 1'b0;
      for (int k = 0; k <= SQ + DL; k++) begin
        vld_r[k] <= 1'b0;
      end
      for (int k = 1; k <= CL; k++) begin
        vt_r[k] <= 1'b0;
      end
    end else if (adv) begin
      v1_r     <= in_tvalid;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      vld_r[0] <= v3_r;
      for (int k = 0; k < SQ + DL; k++) begin
        vld_r[k+1] <= vld_r[k];
      end
      pv1_r   <= vld_r[SQ+DL];
      pv2_r   <= pv1_r;
      pv3_r   <= pv2_r;
      vt_r[1] <= pv3_r;
      for (int k = 1; k < CL; k++) begin
        vt_r[k+1] <= vt_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r          <= s1_nxt;
      s2_r          <= s2_nxt;
      s2_ex_r       <= ex_nxt;
      s2_ey_r       <= ey_nxt;
      s3_r          <= s2_r;
      s3_aex_r      <= s2_ex_r[EW-1] ? AW'(-s2_ex_r) : AW'(s2_ex_r);
      s3_aey_r      <= s2_ey_r[EW-1] ? AW'(-s2_ey_r) : AW'(s2_ey_r);
      s3_sqx_r      <= (2*AW)'(s2_ex_r * s2_ex_r);
      s3_sqy_r      <= (2*AW)'(s2_ey_r * s2_ey_r);
      side_r[0]     <= s3_r;
      sv_r[0]       <= RADW'({(2*AW+1)'(s3_sqx_r) + (2*AW+1)'(s3_sqy_r), 12'b0});
      nx_r[0]       <= NXW'(d_r) * NXW'(s3_aey_r);
      ny_r[0]       <= NXW'(d_r) * NXW'(s3_aex_r);
      for (int k = 0; k < SQ + DL; k++) begin
        side_r[k+1] <= side_r[k];
      end
      for (int k = 0; k < SQ; k++) begin
        nx_r[k+1] <= nx_r[k];
        ny_r[k+1] <= ny_r[k];
      end
    end
  end

  // Integer square root, one result bit per stage.
  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    localparam logic [RADW-1:0] BITV = RADW'(1) << (62 - 2*k);
    logic [RADW-1:0] rin;
    logic [RADW-1:0] trial;
    logic            ge;

    if (k == 0) begin : g_r0
      assign rin = '0;
    end else begin : g_rn
      assign rin = sr_r[k];
    end

    assign trial = rin + BITV;
    assign ge    = sv_r[k] >= trial;

    always_ff @(posedge clk) begin
      if (adv) begin
        sr_r[k+1] <= ge ? ((rin >> 1) + BITV) : (rin >> 1);
      end
    end

    if (k < SQ - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (adv) begin
          sv_r[k+1] <= ge ? (sv_r[k] - trial) : sv_r[k];
        end
      end
    end
  end

  assign ls    = sr_r[SQ][LSW-1:0];
  assign num_x = NUMW'({nx_r[SQ], 8'b0}) + NUMW'(ls);
  assign num_y = NUMW'({ny_r[SQ], 8'b0}) + NUMW'(ls);
  assign den   = {ls, 1'b0};

  bop_div #(.NW(NUMW), .DW(DENW), .QW(QW)) u_div_x (
    .clk   (clk),
    .en    (adv),
    .num_i (num_x),
    .den_i (den),
    .quo_o (qx)
  );

  bop_div #(.NW(NUMW), .DW(DENW), .QW(QW)) u_div_y (
    .clk   (clk),
    .en    (adv),
    .num_i (num_y),
    .den_i (den),
    .quo_o (qy)
  );

  // Candidate selection.
  always_comb begin
    dot = (PW+1)'(p2_px_r) + (PW+1)'(p2_py_r);
    if (dot <= 0) begin
      hx_nxt = HW'($signed(p2_r.sx)) + HW'(p2_o2x_r);
      hy_nxt = HW'($signed(p2_r.sy)) + HW'(p2_o2y_r);
    end else begin
      hx_nxt = HW'($signed(p2_r.sx)) - HW'(p2_o2x_r);
      hy_nxt = HW'($signed(p2_r.sy)) - HW'(p2_o2y_r);
    end
  end

  always_comb begin
    hxp         = ((HW+1)'(p3_hx_r) + (HW+1)'(1)) >>> 1;
    hyp         = ((HW+1)'(p3_hy_r) + (HW+1)'(1)) >>> 1;
    tail_nxt.co = p3_co_r;
    if (hxp > CMAX) begin
      tail_nxt.tx = CMAX[CW-1:0];
    end else if (hxp < CMIN) begin
      tail_nxt.tx = CMIN[CW-1:0];
    end else begin
      tail_nxt.tx = hxp[CW-1:0];
    end
    if (hyp > CMAX) begin
      tail_nxt.ty = CMAX[CW-1:0];
    end else if (hyp < CMIN) begin
      tail_nxt.ty = CMIN[CW-1:0];
    end else begin
      tail_nxt.ty = hyp[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r     <= side_r[SQ+DL];
      p1_o2x_r <= side_r[SQ+DL].eypos ? -$signed(O2W'(qx)) : $signed(O2W'(qx));
      p1_o2y_r <= side_r[SQ+DL].exneg ? -$signed(O2W'(qy)) : $signed(O2W'(qy));
      p2_r     <= p1_r;
      p2_o2x_r <= p1_o2x_r;
      p2_o2y_r <= p1_o2y_r;
      p2_px_r  <= PW'($signed(p1_r.sx)) * PW'(p1_o2x_r);
      p2_py_r  <= PW'($signed(p1_r.sy)) * PW'(p1_o2y_r);
      p3_co_r  <= p2_r.co;
      p3_hx_r  <= hx_nxt;
      p3_hy_r  <= hy_nxt;
      p3_bx_r  <= -BW'($signed(p2_r.dy));
      p3_by_r  <= BW'($signed(p2_r.dx));
      tail_r[1] <= tail_nxt;
      for (int k = 1; k < CL; k++) begin
        tail_r[k+1] <= tail_r[k];
      end
    end
  end

  bop_cordic #(.IW(HW), .STEPS(ST)) u_cordic_target (
    .clk   (clk),
    .en    (adv),
    .x_i   (p3_hx_r),
    .y_i   (p3_hy_r),
    .ang_o (tang)
  );

  bop_cordic #(.IW(BW), .STEPS(ST)) u_cordic_bisector (
    .clk   (clk),
    .en    (adv),
    .x_i   (p3_bx_r),
    .y_i   (p3_by_r),
    .ang_o (bang)
  );

  assign out_tvalid = vt_r[CL];
  assign out_tuser  = tail_r[CL].co;
  assign out_tdata  = tail_r[CL].co ? '0 :
                      OUT_DW'({bang, tang, tail_r[CL].ty, tail_r[CL].tx});

endmodule

// ----- sim/bisector_offset_point_and_angle_tb.sv -----
// ----------------------------------------------------------------------------
// Bisector offset point testbench
// Streams point pairs through the block under random idling on both sides,
// predicts every result in the bench and checks it field by field.
// ----------------------------------------------------------------------------
module bisector_offset_point_and_angle_tb import bop_pkg::*;;

  localparam int CW = 24;
  localparam int STEPS = 16;
  localparam int LATENCY = 66 + STEPS;

  typedef struct packed {
    logic signed [CW-1:0] tx;
    logic signed [CW-1:0] ty;
    logic signed [ANGW-1:0] tang;
    logic signed [ANGW-1:0] bang;
    logic coinc;
  } target_t;

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint clamp_coord(longint v);
    longint hi, lo;
    hi = (64'sd1 <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint cw_angle(longint x, longint y);
    longint z, r, q, m, xs, ys;
    z = 0;
    if (x == 0) begin
      if (y > 0) return -ANGLE_LIMIT;
      if (y < 0) return ANGLE_LIMIT;
      return 0;
    end
    if (y == 0) return 0;
    if (x < 0) begin
      x = -x;
      y = -y;
    end
    m = x > mag(y) ? x : mag(y);
    while (m >= (64'sd1 <<< 51)) begin
      x = shr_floor(x, 1);
      y = shr_floor(y, 1);
      m >>= 1;
    end
    while (m < (64'sd1 <<< 50)) begin
      x *= 2;
      y *= 2;
      m *= 2;
    end
    for (int i = 0; i < STEPS && i < ATAN_N; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (y > 0) begin
        x += ys;
        y -= xs;
        z += longint'(ATAN_TAB[i]);
      end else begin
        x -= ys;
        y += xs;
        z -= longint'(ATAN_TAB[i]);
      end
    end
    r = -z;
    q = (mag(r) + 128) / 256;
    if (r < 0) q = -q;
    if (q > ANGLE_LIMIT) q = ANGLE_LIMIT;
    if (q < -ANGLE_LIMIT) q = -ANGLE_LIMIT;
    return q;
  endfunction

  function automatic target_t offset_target(logic [4*CW-1:0] pts, longint unsigned offset_d);
    target_t t;
    longint ax, ay, bx, by, dx, dy, ex, ey, o2x, o2y, sx, sy, hx, hy, dot;
    longint unsigned ls, qx, qy;
    ax = longint'($signed(pts[CW-1:0]));
    ay = longint'($signed(pts[2*CW-1:CW]));
    bx = longint'($signed(pts[3*CW-1:2*CW]));
    by = longint'($signed(pts[4*CW-1:3*CW]));
    dx = bx - ax;
    dy = by - ay;
    t = '0;
    if (dx == 0 && dy == 0) begin
      t.coinc = 1'b1;
      return t;
    end
    ex = dx;
    ey = dy;
    while (mag(ex) >= (64'sd1 <<< 25) || mag(ey) >= (64'sd1 <<< 25)) begin
      ex = shr_floor(ex, 1);
      ey = shr_floor(ey, 1);
    end
    ls = int_sqrt((longint'(ex * ex) + longint'(ey * ey)) << 12);
    qx = (2 * (2 * offset_d * 64 * mag(ey)) + ls) / (2 * ls);
    qy = (2 * (2 * offset_d * 64 * mag(ex)) + ls) / (2 * ls);
    o2x = ey > 0 ? -longint'(qx) : longint'(qx);
    o2y = ex < 0 ? -longint'(qy) : longint'(qy);
    sx = ax + bx;
    sy = ay + by;
    dot = sx * o2x + sy * o2y;
    if (dot <= 0) begin
      hx = sx + o2x;
      hy = sy + o2y;
    end else begin
      hx = sx - o2x;
      hy = sy - o2y;
    end
    t.tx = CW'(clamp_coord(shr_floor(hx + 1, 1)));
    t.ty = CW'(clamp_coord(shr_floor(hy + 1, 1)));
    t.tang = ANGW'(cw_angle(hx, hy));
    t.bang = ANGW'(cw_angle(-dy, dx));
    return t;
  endfunction

  class target_board;
    target_t pending[$];
    longint unsigned offset_dist = DIST_RESET;
    int errors = 0;

    function void note_pair(logic [4*CW-1:0] pts);
      pending = {pending, offset_target(pts, offset_dist)};
    endfunction

    function void check_target(target_t got);
      target_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.tx !== exp.tx) begin
        $display("%0t: target_x expected %0d actual %0d", $time, exp.tx, got.tx);
        errors++;
      end
      if (got.ty !== exp.ty) begin
        $display("%0t: target_y expected %0d actual %0d", $time, exp.ty, got.ty);
        errors++;
      end
      if (got.tang !== exp.tang) begin
        $display("%0t: target_angle expected %0d actual %0d", $time, exp.tang, got.tang);
        errors++;
      end
      if (got.bang !== exp.bang) begin
        $display("%0t: bisector_angle expected %0d actual %0d", $time, exp.bang, got.bang);
        errors++;
      end
      if (got.coinc !== exp.coinc) begin
        $display("%0t: coincident expected %0b actual %0b", $time, exp.coinc, got.coinc);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [4*CW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [2*CW+2*ANGW-1:0] out_tdata;
  logic out_tuser;
  logic cfg_we = 0;
  logic [DISTW-1:0] cfg_wdata = '0;
  bit sink_idle = 0;
  target_board board = new();

  always #5 clk = ~clk;

  bisector_offset_point_and_angle #(.COORD_WIDTH(CW), .CORDIC_STEPS(STEPS)) dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .out_tuser, .cfg_we, .cfg_wdata
  );

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_target({out_tdata[CW-1:0], out_tdata[2*CW-1:CW],
        out_tdata[2*CW+ANGW-1:2*CW], out_tdata[2*CW+2*ANGW-1:2*CW+ANGW], out_tuser});
    end
  end

  initial begin
    int wait_cycles;
    @(posedge clk);
    while (1) begin
      if (sink_idle) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        wait_cycles = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) wait_cycles = 0;
        if (wait_cycles > 0) begin
          out_tready <= 1'b0;
          repeat (wait_cycles) @(posedge clk);
        end
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_pair(logic signed [CW-1:0] ax, logic signed [CW-1:0] ay,
                           logic signed [CW-1:0] bx, logic signed [CW-1:0] by, bit gaps);
    int wait_cycles;
    wait_cycles = gaps ? $urandom_range(0, 12) : 0;
    if (wait_cycles > 0) begin
      in_tvalid <= 1'b0;
      repeat (wait_cycles) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {by, bx, ay, ax};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_pair({by, bx, ay, ax});
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_dist(logic [DISTW-1:0] d);
    cfg_we <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.offset_dist = d;
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
      1: return CW'($signed($urandom_range(0, 4000)) - 2000);
      2: return CW'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic random_pairs(int count);
    logic signed [CW-1:0] ax, ay, bx, by;
    bit gaps;
    for (int i = 0; i < count; i++) begin
      gaps = (i % 80) >= 20;
      ax = rand_coord();
      ay = rand_coord();
      case ($urandom_range(0, 9))
        0: begin bx = ax; by = ay; end
        1: begin bx = ax; by = rand_coord(); end
        2: begin bx = rand_coord(); by = ay; end
        3: begin bx = ax + CW'($signed($urandom_range(0, 8)) - 4);
                 by = ay + CW'($signed($urandom_range(0, 8)) - 4); end
        default: begin bx = rand_coord(); by = rand_coord(); end
      endcase
      send_pair(ax, ay, bx, by, gaps);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_pair(0, 0, 24'sd65536, 0, 0);
    send_pair(24'sd100, 24'sd200, 24'sd100, 24'sd200, 0);
    send_pair(0, 0, 0, 0, 0);
    send_pair(24'sd65536, 0, 24'sd65536, 24'sd65536, 0);
    send_pair(24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 24'sh7ffff0, 0);
    send_pair(24'sh800000, 24'sh800000, 24'sh7fffff, 24'sh7fffff, 0);
    send_pair(24'sh800000, 24'sh7fffff, 24'sh7fffff, 24'sh800000, 0);
    send_pair(24'sh800000, 24'sh800000, 24'sh800000, 24'sh7fffff, 0);
    send_pair(-24'sd65536, 0, 24'sd65536, 0, 0);
    send_pair(0, -24'sd65536, 0, 24'sd65536, 0);
    send_pair(24'sd1, 0, 0, 24'sd1, 0);
    send_pair(24'sd131072, 24'sd131072, 24'sd196608, 24'sd65536, 0);
    drain();
    write_dist('0);
    send_pair(24'sd65536, 24'sd65536, 24'sd131072, 24'sd196608, 0);
    send_pair(-24'sd3, 24'sd5, 24'sd7, -24'sd2, 0);
    send_pair(24'sh7fffff, 0, 24'sh7ffffd, 24'sd1, 0);
    random_pairs(60);
    drain();
    write_dist(20'd655360);
    send_pair(24'sh7f0000, 24'sh7f0000, 24'sh7f0000, 24'sh700000, 0);
    send_pair(24'sh810000, 24'sh810000, 24'sh900000, 24'sh810000, 0);
    random_pairs(180);
    drain();
    write_dist(20'hfffff);
    random_pairs(80);
    drain();
    write_dist(20'd1);
    random_pairs(60);
    drain();
    write_dist(DIST_RESET);
    random_pairs(100);
    drain();
    sink_idle = 1;
    write_dist(DISTW'($urandom_range(0, 655360)));
    random_pairs(120);
    drain();
    if (board.errors == 0) begin
      $display("bisector_offset_point_and_angle_tb: PASS");
    end else begin
      $display("bisector_offset_point_and_angle_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("bisector_offset_point_and_angle_tb: FAIL");
    $finish;
  end

endmodule
